/* hdl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: implication");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

// condition never true, masked during reset
`define ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("assertion failed: forbidden condition");

`endif

/* hdl/tqp_pkg.sv */
// shared widths, defaults and control types for the tone queue player
// no dependencies
`timescale 1ns / 1ps

package tqp_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int TONE_W = 16;
    localparam int DUR_W  = 15;
    localparam int TIME_W = 16;
    localparam int FREE_W = 4;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // request kinds carried on s_tuser
    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // request accepted, capture the input fields
        logic exec;   // apply the captured request to the queue state
    } cmd_t;

endpackage

/* hdl/tone_queue_player_unit.sv */
// top level of the tone queue player: stream ports, controller and datapath
// depends on tqp_pkg, tqp_ctrl, tqp_datapath
//
// channel   direction  tdata fields (low bit up)                      tuser
// s_        in         tone[15:0] length_ms[30:16] now_ms[46:31] pad  func
// m_        out        drive_on drive_tone drive_changed playing free -
//
// each request passes through three steps:
// accept, apply (queue read data registered at accept), present result
// the next request is accepted only after the result has been taken
// a stalled result holds m_tdata stable for as long as m_tready stays low
// aresetn is synchronous, active low; it empties the queue and stops the drive
// queue contents are not cleared, only entries written since are ever read
`timescale 1ns / 1ps

module tone_queue_player_unit #(
    parameter int QUEUE_DEPTH = tqp_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tone[15:0], length_ms[30:16], now_ms[46:31], zero pad [47]
    input  logic [tqp_pkg::S_TDATA_W-1:0] s_tdata,
    // func: 0 enqueue, 1 time tick
    input  logic [0:0]                    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // drive_on[0], drive_tone[16:1], drive_changed[17], playing[18],
    // free_space[22:19], zero pad [23]
    output logic [tqp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    tqp_pkg::cmd_t cmd;

    logic                       drive_on;
    logic [tqp_pkg::TONE_W-1:0] drive_tone;
    logic                       drive_changed;
    logic                       playing;
    logic [tqp_pkg::FREE_W-1:0] free_space;

    // sequencer: accept, apply, present
    tqp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // queue, timer and result registers
    tqp_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .in_func           (s_tuser[0]),
        .in_tone           (s_tdata[15:0]),
        .in_length_ms      (s_tdata[30:16]),
        .in_now_ms         (s_tdata[46:31]),
        .out_drive_on      (drive_on),
        .out_drive_tone    (drive_tone),
        .out_drive_changed (drive_changed),
        .out_playing       (playing),
        .out_free_space    (free_space)
    );

    // pack the result, pad bit zero
    assign m_tdata = {1'b0, free_space, playing, drive_changed, drive_tone, drive_on};

endmodule

/* hdl/tqp_ctrl.sv */
// handshake sequencer for the tone queue player
// depends on tqp_pkg
`timescale 1ns / 1ps

module tqp_ctrl (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output tqp_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign cmd.load = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

/* hdl/tqp_datapath.sv */
// queue storage, pointers, deadline timer and result registers
// depends on tqp_pkg
`timescale 1ns / 1ps

module tqp_datapath #(
    parameter int QUEUE_DEPTH = tqp_pkg::QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tqp_pkg::cmd_t               cmd,
    input  logic                        in_func,
    input  logic [tqp_pkg::TONE_W-1:0]  in_tone,
    input  logic [tqp_pkg::DUR_W-1:0]   in_length_ms,
    input  logic [tqp_pkg::TIME_W-1:0]  in_now_ms,
    output logic                        out_drive_on,
    output logic [tqp_pkg::TONE_W-1:0]  out_drive_tone,
    output logic                        out_drive_changed,
    output logic                        out_playing,
    output logic [tqp_pkg::FREE_W-1:0]  out_free_space
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = (PW + 1 > tqp_pkg::FREE_W) ? PW + 1 : tqp_pkg::FREE_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    logic [tqp_pkg::TONE_W-1:0] mem_tone [QUEUE_DEPTH];
    logic [tqp_pkg::DUR_W-1:0]  mem_dur  [QUEUE_DEPTH];
    logic [tqp_pkg::TONE_W-1:0] rd_tone_reg;
    logic [tqp_pkg::DUR_W-1:0]  rd_dur_reg;

    // captured request
    logic                       func_reg;
    logic [tqp_pkg::TONE_W-1:0] tone_reg;
    logic [tqp_pkg::DUR_W-1:0]  dur_reg;
    logic [tqp_pkg::TIME_W-1:0] now_reg;

    // player state
    logic [PW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic                       active_reg, active_next;
    logic [tqp_pkg::TIME_W-1:0] deadline_reg, deadline_next;
    logic [tqp_pkg::TONE_W-1:0] cur_tone_reg, cur_tone_next;

    logic                       we;
    logic                       changed;
    logic [PW-1:0]              wr_inc, rd_inc;
    logic                       empty;
    logic [tqp_pkg::TIME_W-1:0] diff;
    logic                       elapsed;
    logic [CW-1:0]              used;
    logic [CW-1:0]              free_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    // storage: one write port, one registered read at the read pointer
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_tone[wr_ptr_reg] <= tone_reg;
            mem_dur[wr_ptr_reg]  <= dur_reg;
        end
        rd_tone_reg <= mem_tone[rd_ptr_reg];
        rd_dur_reg  <= mem_dur[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            tone_reg <= in_tone;
            dur_reg  <= in_length_ms;
            now_reg  <= in_now_ms;
        end
    end

    assign wr_inc  = ptr_inc(wr_ptr_reg);
    assign rd_inc  = ptr_inc(rd_ptr_reg);
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign diff    = now_reg - deadline_reg;
    assign elapsed = ~diff[tqp_pkg::TIME_W-1];

    always_comb begin
        we            = 1'b0;
        changed       = 1'b0;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        active_next   = active_reg;
        deadline_next = deadline_reg;
        cur_tone_next = cur_tone_reg;
        if (cmd.exec) begin
            if (func_reg == tqp_pkg::FUNC_ENQUEUE) begin
                // enqueue, dropping the oldest entry when full
                we          = 1'b1;
                wr_ptr_next = wr_inc;
                if (wr_inc == rd_ptr_reg) begin
                    rd_ptr_next = rd_inc;
                end
            end else if (!active_reg || elapsed) begin
                if (!empty) begin
                    rd_ptr_next   = rd_inc;
                    deadline_next = now_reg + tqp_pkg::TIME_W'(rd_dur_reg);
                    cur_tone_next = rd_tone_reg;
                    active_next   = 1'b1;
                    changed       = 1'b1;
                end else if (active_reg) begin
                    cur_tone_next = '0;
                    active_next   = 1'b0;
                    changed       = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (wr_ptr_next >= rd_ptr_next) begin
            used = CW'(wr_ptr_next) - CW'(rd_ptr_next);
        end else begin
            used = CW'(wr_ptr_next) + CW'(QUEUE_DEPTH) - CW'(rd_ptr_next);
        end
        free_cnt = CW'(QUEUE_DEPTH - 1) - used;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            active_reg   <= 1'b0;
            deadline_reg <= '0;
            cur_tone_reg <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            active_reg   <= active_next;
            deadline_reg <= deadline_next;
            cur_tone_reg <= cur_tone_next;
        end
    end

    // result registers, held until the next request is applied
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_drive_on      <= (cur_tone_next != '0);
            out_drive_tone    <= cur_tone_next;
            out_drive_changed <= changed;
            out_playing       <= active_next;
            out_free_space    <= free_cnt[tqp_pkg::FREE_W-1:0];
        end
    end

endmodule

/* hdl/tqp_checker.sv */
// port-level checks for the tone queue player, bound to the top level
// depends on assert_macros.svh, tqp_pkg, tone_queue_player_unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tqp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [tqp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // and its payload does not move
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    // one request in flight: no accept while a result waits
    `ASSERT_NEVER(a_one_in_flight, aclk, aresetn, s_tready && m_tvalid && s_tvalid)
    // drive flag follows the driven tone
    `ASSERT_IMPLIES(a_drive_flag, aclk, aresetn, m_tvalid, m_tdata[0] == (m_tdata[16:1] != 16'd0))
    // idle player drives nothing
    `ASSERT_IMPLIES(a_idle_silent, aclk, aresetn, m_tvalid && !m_tdata[18], m_tdata[16:1] == 16'd0)

endmodule

bind tone_queue_player_unit tqp_checker u_tqp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
